[rtl/core/dcsf_pkg.sv]
// ----------------------------------------------------------------------------
// dcsf_pkg
// shared types, codes and helpers of the dual current-sense filter
// ----------------------------------------------------------------------------
`default_nettype none

package dcsf_pkg;

  // operand width of the shared multiplier (signed)
  localparam int unsigned MulW  = 17;
  // product width
  localparam int unsigned ProdW = 2 * MulW;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNELS_ATTACHED = 3'd0,
    REG_CURRENT_SCALE     = 3'd1,
    REG_OFFSET_LEFT       = 3'd2,
    REG_OFFSET_RIGHT      = 3'd3,
    REG_FILTER_ALPHA      = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_ERROR     = 2'd2,
    STATUS_UNUSED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_FILT_L,
    ST_FILT_R,
    ST_FILT_DONE,
    ST_OUT
  } seq_state_e;

  typedef logic signed [ProdW-1:0] prod_t;

  // clamp a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(prod_t v);
    logic signed [15:0] r;
    if (v > prod_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -prod_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dual_current_sense_filter_core.sv]
// ----------------------------------------------------------------------------
// dual_current_sense_filter_core
// adc event handling, current scaling and first-order low-pass for two channels
// ----------------------------------------------------------------------------
// Each input transaction is one ADC event (start result or poll result) and
// produces exactly one output transaction showing the block state after the
// event. Flags and counters update in the cycle the event is taken. A fresh
// sample pair then runs through one shared 17x17 signed multiplier four times
// (left scale, right scale, left filter, right filter), one product per
// cycle, stepping through ST_SCALE_L, ST_SCALE_R, ST_FILT_L, ST_FILT_R and
// ST_FILT_DONE to ST_OUT, where the result is loaded into the output
// register; any other event goes straight to ST_OUT. in_stall_o stays high
// until the result is loaded, so the next event waits for that, longer
// when a finished result has to wait for the output register. The output sits
// in a register, so a new event can be taken while the previous result still
// waits downstream. The configuration port is always ready and should be
// written only while the block is idle.
`default_nettype none

module dual_current_sense_filter_core
  import dcsf_pkg::*;
#(
  parameter int unsigned ADC_BITS        = 12,
  parameter int unsigned ERROR_RUN_LIMIT = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [15:0]           cfg_data_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [1:0]            read_status_i,
  input  wire logic [ADC_BITS-1:0]   raw_left_i,
  input  wire logic [ADC_BITS-1:0]   raw_right_i,
  input  wire logic [31:0]           sequence_req_i,
  input  wire logic [15:0]           timer_count_i,
  input  wire logic [15:0]           timer_period_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       sample_valid_o,
  output logic                       acq_running_o,
  output logic                       restart_request_o,
  output logic signed [15:0]         current_left_ma_o,
  output logic signed [15:0]         current_right_ma_o,
  output logic signed [15:0]         filtered_left_ma_o,
  output logic signed [15:0]         filtered_right_ma_o,
  output logic [31:0]                good_samples_o,
  output logic [31:0]                error_total_o,
  output logic [31:0]                restart_total_o,
  output logic [15:0]                timer_count_seen_o,
  output logic [15:0]                timer_period_seen_o
);

  localparam logic [3:0] RunLimit = 4'(ERROR_RUN_LIMIT);

  // configuration registers
  logic               attached_q;
  logic [15:0]        scale_q;
  logic signed [15:0] off_l_q, off_r_q;
  logic [15:0]        alpha_q;

  // block state
  seq_state_e         state_q, state_d;
  logic               valid_q, valid_d;
  logic               alive_q, alive_d;
  logic               restart_q, restart_d;
  logic [3:0]         run_q, run_d;
  logic [31:0]        last_seq_q, last_seq_d;
  logic signed [15:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic signed [15:0] filt_l_q, filt_l_d, filt_r_q, filt_r_d;
  logic [31:0]        samples_q, samples_d;
  logic [31:0]        errors_q, errors_d;
  logic [31:0]        restarts_q, restarts_d;
  logic [15:0]        tcnt_q, tcnt_d, tper_q, tper_d;
  logic [ADC_BITS-1:0] raw_l_q, raw_l_d, raw_r_q, raw_r_d;

  // shared multiplier
  logic signed [MulW-1:0] mul_a, mul_b;
  prod_t                  prod_q, prod_d;
  prod_t                  scaled, filt_sum_l, filt_sum_r;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  logic               in_take;
  logic [3:0]         run_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign run_inc     = run_q + 4'd1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= 1'b0;
      scale_q    <= 16'd256;
      off_l_q    <= '0;
      off_r_q    <= '0;
      alpha_q    <= 16'd8192;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CHANNELS_ATTACHED: attached_q <= cfg_data_i[0];
        REG_CURRENT_SCALE:     scale_q    <= cfg_data_i;
        REG_OFFSET_LEFT:       off_l_q    <= cfg_data_i;
        REG_OFFSET_RIGHT:      off_r_q    <= cfg_data_i;
        REG_FILTER_ALPHA:      alpha_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, scale_q});
    case (state_q)
      ST_SCALE_L: mul_a = $signed({{(MulW-ADC_BITS){1'b0}}, raw_l_q});
      ST_SCALE_R: mul_a = $signed({{(MulW-ADC_BITS){1'b0}}, raw_r_q});
      ST_FILT_L: begin
        mul_a = MulW'(cur_l_q) - MulW'(filt_l_q);
        mul_b = $signed({1'b0, alpha_q});
      end
      ST_FILT_R: begin
        mul_a = MulW'(cur_r_q) - MulW'(filt_r_q);
        mul_b = $signed({1'b0, alpha_q});
      end
      default: ;
    endcase
  end

  assign prod_d = prod_t'(mul_a) * prod_t'(mul_b);

  // scaled milliamps minus offset; the offset follows the channel in flight
  assign scaled = (prod_q >>> 8) -
                  ((state_q == ST_SCALE_R) ? prod_t'(off_l_q) : prod_t'(off_r_q));
  // floor shift of alpha*(x-y) added onto the filter state
  assign filt_sum_l = prod_t'(filt_l_q) + (prod_q >>> 16);
  assign filt_sum_r = prod_t'(filt_r_q) + (prod_q >>> 16);

  // sequencer and state update
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    alive_d     = alive_q;
    restart_d   = restart_q;
    run_d       = run_q;
    last_seq_d  = last_seq_q;
    cur_l_d     = cur_l_q;
    cur_r_d     = cur_r_q;
    filt_l_d    = filt_l_q;
    filt_r_d    = filt_r_q;
    samples_d   = samples_q;
    errors_d    = errors_q;
    restarts_d  = restarts_q;
    tcnt_d      = tcnt_q;
    tper_d      = tper_q;
    raw_l_d     = raw_l_q;
    raw_r_d     = raw_r_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d   = ST_OUT;
          restart_d = 1'b0;
          if (op_i == OP_START) begin
            run_d      = '0;
            last_seq_d = '0;
            alive_d    = 1'b0;
            valid_d    = 1'b0;
            if (attached_q) begin
              if (read_status_i == STATUS_OK) begin
                alive_d = 1'b1;
              end else begin
                errors_d = errors_q + 32'd1;
              end
            end
          end else if (!attached_q || read_status_i == STATUS_NOT_READY) begin
            valid_d = 1'b0;
          end else if (read_status_i != STATUS_OK) begin
            // error or unused code: count it, restart after a run of them
            errors_d = errors_q + 32'd1;
            valid_d  = 1'b0;
            alive_d  = 1'b0;
            run_d    = run_inc;
            if (run_inc >= RunLimit) begin
              restarts_d = restarts_q + 32'd1;
              run_d      = '0;
              last_seq_d = '0;
              restart_d  = 1'b1;
            end
          end else if (sequence_req_i != last_seq_q) begin
            // fresh pair
            state_d    = ST_SCALE_L;
            last_seq_d = sequence_req_i;
            run_d      = '0;
            alive_d    = 1'b1;
            valid_d    = 1'b1;
            samples_d  = samples_q + 32'd1;
            tcnt_d     = timer_count_i;
            tper_d     = timer_period_i;
            raw_l_d    = raw_left_i;
            raw_r_d    = raw_right_i;
          end
        end
      end
      ST_SCALE_L: state_d = ST_SCALE_R;
      ST_SCALE_R: begin
        cur_l_d = sat16(scaled);
        state_d = ST_FILT_L;
      end
      ST_FILT_L: begin
        cur_r_d = sat16(scaled);
        state_d = ST_FILT_R;
      end
      ST_FILT_R: begin
        filt_l_d = sat16(filt_sum_l);
        state_d  = ST_FILT_DONE;
      end
      ST_FILT_DONE: begin
        filt_r_d = sat16(filt_sum_r);
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= 1'b0;
      alive_q     <= 1'b0;
      restart_q   <= 1'b0;
      run_q       <= '0;
      last_seq_q  <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
      filt_l_q    <= '0;
      filt_r_q    <= '0;
      samples_q   <= '0;
      errors_q    <= '0;
      restarts_q  <= '0;
      tcnt_q      <= '0;
      tper_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      alive_q     <= alive_d;
      restart_q   <= restart_d;
      run_q       <= run_d;
      last_seq_q  <= last_seq_d;
      cur_l_q     <= cur_l_d;
      cur_r_q     <= cur_r_d;
      filt_l_q    <= filt_l_d;
      filt_r_q    <= filt_r_d;
      samples_q   <= samples_d;
      errors_q    <= errors_d;
      restarts_q  <= restarts_d;
      tcnt_q      <= tcnt_d;
      tper_q      <= tper_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    raw_l_q <= raw_l_d;
    raw_r_q <= raw_r_d;
    prod_q  <= prod_d;
    if (out_load) begin
      sample_valid_o      <= valid_q;
      acq_running_o       <= alive_q;
      restart_request_o   <= restart_q;
      current_left_ma_o   <= cur_l_q;
      current_right_ma_o  <= cur_r_q;
      filtered_left_ma_o  <= filt_l_q;
      filtered_right_ma_o <= filt_r_q;
      good_samples_o      <= samples_q;
      error_total_o       <= errors_q;
      restart_total_o     <= restarts_q;
      timer_count_seen_o  <= tcnt_q;
      timer_period_seen_o <= tper_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/dcsf_checker.sv]
// ----------------------------------------------------------------------------
// dcsf_checker
// port-level checks of the dual current-sense filter core
// ----------------------------------------------------------------------------
`default_nettype none

module dcsf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        sample_valid_o,
  input wire logic        acq_running_o,
  input wire logic        restart_request_o,
  input wire logic [31:0] good_samples_o
);

  // a stalled result stays and holds its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(good_samples_o))
    else $error("stalled output transaction changed");

  // the block is busy in the cycle after it accepts an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transaction");

  // a restart pulse comes with the acquisition marked down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restart_request_o |-> !acq_running_o && !sample_valid_o)
    else $error("restart request while acquisition alive");

  // a fresh sample implies a live acquisition
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> acq_running_o)
    else $error("valid sample without live acquisition");

endmodule

bind dual_current_sense_filter_core dcsf_checker u_dcsf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .sample_valid_o    (sample_valid_o),
  .acq_running_o     (acq_running_o),
  .restart_request_o (restart_request_o),
  .good_samples_o    (good_samples_o)
);

`default_nettype wire
